// File: hw/rtl/tasc_pkg.sv
package tasc_pkg;

  typedef enum logic [2:0] {
    ALARM_IDLE         = 3'd0,
    ALARM_CAUTION_LOW  = 3'd1,
    ALARM_CAUTION_HIGH = 3'd2,
    ALARM_NO_READ      = 3'd3,
    ALARM_LOW          = 3'd4,
    ALARM_HIGH         = 3'd5,
    ALARM_EXTERNAL     = 3'd6
  } alarm_e;

  typedef enum logic [1:0] {
    OP_EVAL   = 2'd0,
    OP_PRESS  = 2'd1,
    OP_REMOTE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SOUND_NONE   = 2'd0,
    SOUND_WARN   = 2'd1,
    SOUND_URGENT = 2'd2
  } sound_e;

  localparam logic [2:0] CfgAlarmsEnabled = 3'd0;
  localparam logic [2:0] CfgAlarmLow      = 3'd1;
  localparam logic [2:0] CfgWarnLow       = 3'd2;
  localparam logic [2:0] CfgAlarmHigh     = 3'd3;
  localparam logic [2:0] CfgWarnHigh      = 3'd4;
  localparam logic [2:0] CfgNoReadingsMin = 3'd5;
  localparam logic [2:0] CfgRepeatMin     = 3'd6;
  localparam logic [2:0] CfgSnoozeMin     = 3'd7;

  localparam logic [2:0] RemoteUrgentLow  = 3'd1;
  localparam logic [2:0] RemoteUrgentHigh = 3'd4;

  localparam logic [31:0] RemoteHoldSec = 32'd1800;
  localparam logic [31:0] PressWindowMs = 32'd2000;
  localparam logic [9:0]  MinValidMgdl  = 10'd10;
  localparam logic [2:0]  MaxSnoozeMult = 3'd4;
  localparam logic [15:0] SecPerMin     = 16'd60;
  localparam logic [32:0] CeilMinBias   = 33'd59;
  localparam logic [31:0] Div15Magic    = 32'h8888_8889;
  localparam int unsigned Div15Shift    = 35;

  typedef struct packed {
    logic       alarms_enabled;
    logic [9:0] alarm_low;
    logic [9:0] warn_low;
    logic [9:0] alarm_high;
    logic [9:0] warn_high;
    logic [7:0] no_readings_min;
    logic [7:0] repeat_min;
    logic [7:0] snooze_min;
  } cfg_t;

  typedef struct packed {
    alarm_e      cur_alarm;
    logic        ever_sounded;
    logic [31:0] last_sound_time;
    logic [2:0]  remote_held;
    logic [31:0] remote_since;
    logic [2:0]  snooze_mult;
    logic [31:0] snooze_until;
    logic [31:0] last_press_ms;
    logic        press_valid;
  } state_t;

  typedef struct packed {
    op_e         operation;
    logic [31:0] now_sec;
    logic [31:0] now_ms;
    logic        has_data;
    logic [9:0]  glucose_mgdl;
    logic        reading_stale;
    logic [15:0] minutes_since_reading;
    logic [31:0] reading_time_sec;
    logic [2:0]  remote_code;
  } item_t;

  typedef struct packed {
    alarm_e      alarm;
    logic        changed;
    sound_e      sound;
    logic [2:0]  snooze_mult;
    logic [31:0] snooze_until;
    logic [2:0]  remote_held;
    logic [31:0] last_sound_time;
    logic [31:0] now_sec;
    logic        has_data;
    logic [31:0] reading_time_sec;
  } mid_t;

endpackage

// File: hw/rtl/threshold_alarm_snooze_controller.sv
// Alarm and snooze manager for one sensor reading.
// Input channel (in_valid_i/in_ready_o) carries one event beat: evaluate,
// snooze press, remote alarm or clear snooze, with the reading fields.
// Output channel (out_valid_o/out_ready_i) returns exactly one result beat
// per input beat, in order: alarm state, change flag, sound request,
// snooze level and minutes left, held remote code and next wake time.
// A beat taken into the input register moves to the middle register and then
// to the output register. One beat per cycle while the receiver keeps taking
// beats; the alarm state is updated in the first stage so each event sees the
// previous one's effect at once, and the second stage holds the minutes-left
// division (a multiply by a constant reciprocal) and the next-wake selection.
// Each of the three stage registers advances only where the stage ahead is
// free or passing its beat on, so a stalled receiver holds its beat and backs
// up to in_ready_o only once every stage is full.
// Reset clears the pipeline, the alarm and snooze state, and loads the
// register defaults. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i, by the user only while no beat is in flight; not enforced.
module threshold_alarm_snooze_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tasc_pkg::op_e      operation_i,
  input  logic [31:0]        now_sec_i,
  input  logic [31:0]        now_ms_i,
  input  logic               has_data_i,
  input  logic [9:0]         glucose_mgdl_i,
  input  logic               reading_stale_i,
  input  logic [15:0]        minutes_since_reading_i,
  input  logic [31:0]        reading_time_sec_i,
  input  logic [2:0]         remote_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         alarm_state_o,
  output logic               state_changed_o,
  output logic [1:0]         sound_request_o,
  output logic [2:0]         snooze_level_o,
  output logic [9:0]         snooze_left_min_o,
  output logic [2:0]         active_remote_code_o,
  output logic [31:0]        next_wake_sec_o
);
  import tasc_pkg::*;

  cfg_t   cfg_q, cfg_d;
  state_t state_q, state_d;
  item_t  item_q;
  mid_t   mid_d, mid_q;
  logic   s1_v_q, s1_v_d;
  logic   s2_v_q, s2_v_d;
  logic   out_v_q, out_v_d;
  logic   out_go, s2_go, s1_fire;
  logic [9:0]  left_d;
  logic [31:0] wake_d;

  logic [2:0]  alarm_q;
  logic        changed_q;
  logic [1:0]  sound_q;
  logic [2:0]  level_q;
  logic [9:0]  left_q;
  logic [2:0]  remote_q;
  logic [31:0] wake_q;

  assign out_go     = !out_v_q || out_ready_i;
  assign s2_go      = !s2_v_q || out_go;
  assign in_ready_o = !s1_v_q || s2_go;
  assign s1_fire    = s1_v_q && s2_go;

  always_comb begin
    s1_v_d  = in_ready_o ? in_valid_i : s1_v_q;
    s2_v_d  = s2_go ? s1_v_q : s2_v_q;
    out_v_d = out_go ? s2_v_q : out_v_q;
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAlarmsEnabled: cfg_d.alarms_enabled  = cfg_wdata_i[0];
        CfgAlarmLow:      cfg_d.alarm_low       = cfg_wdata_i;
        CfgWarnLow:       cfg_d.warn_low        = cfg_wdata_i;
        CfgAlarmHigh:     cfg_d.alarm_high      = cfg_wdata_i;
        CfgWarnHigh:      cfg_d.warn_high       = cfg_wdata_i;
        CfgNoReadingsMin: cfg_d.no_readings_min = cfg_wdata_i[7:0];
        CfgRepeatMin:     cfg_d.repeat_min      = cfg_wdata_i[7:0];
        CfgSnoozeMin:     cfg_d.snooze_min      = cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  tasc_update u_update (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .mid_o   (mid_d)
  );

  tasc_finish u_finish (
    .cfg_i             (cfg_q),
    .mid_i             (mid_q),
    .snooze_left_min_o (left_d),
    .next_wake_sec_o   (wake_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cfg_q.alarms_enabled  <= 1'b1;
      cfg_q.alarm_low       <= 10'd55;
      cfg_q.warn_low        <= 10'd70;
      cfg_q.alarm_high      <= 10'd260;
      cfg_q.warn_high       <= 10'd180;
      cfg_q.no_readings_min <= 8'd15;
      cfg_q.repeat_min      <= 8'd5;
      cfg_q.snooze_min      <= 8'd30;
      state_q.cur_alarm       <= ALARM_IDLE;
      state_q.ever_sounded    <= 1'b0;
      state_q.last_sound_time <= 32'd0;
      state_q.remote_held     <= 3'd0;
      state_q.remote_since    <= 32'd0;
      state_q.snooze_mult     <= 3'd0;
      state_q.snooze_until    <= 32'd0;
      state_q.last_press_ms   <= 32'd0;
      state_q.press_valid     <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      out_v_q <= out_v_d;
      cfg_q   <= cfg_d;
      if (s1_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.operation             <= operation_i;
      item_q.now_sec               <= now_sec_i;
      item_q.now_ms                <= now_ms_i;
      item_q.has_data              <= has_data_i;
      item_q.glucose_mgdl          <= glucose_mgdl_i;
      item_q.reading_stale         <= reading_stale_i;
      item_q.minutes_since_reading <= minutes_since_reading_i;
      item_q.reading_time_sec      <= reading_time_sec_i;
      item_q.remote_code           <= remote_code_i;
    end
    if (s1_fire) begin
      mid_q <= mid_d;
    end
    if (s2_v_q && out_go) begin
      alarm_q   <= mid_q.alarm;
      changed_q <= mid_q.changed;
      sound_q   <= mid_q.sound;
      level_q   <= mid_q.snooze_mult;
      left_q    <= left_d;
      remote_q  <= mid_q.remote_held;
      wake_q    <= wake_d;
    end
  end

  assign out_valid_o          = out_v_q;
  assign alarm_state_o        = alarm_q;
  assign state_changed_o      = changed_q;
  assign sound_request_o      = sound_q;
  assign snooze_level_o       = level_q;
  assign snooze_left_min_o    = left_q;
  assign active_remote_code_o = remote_q;
  assign next_wake_sec_o      = wake_q;

endmodule

// File: hw/rtl/tasc_update.sv
module tasc_update (
  input  tasc_pkg::cfg_t   cfg_i,
  input  tasc_pkg::state_t state_i,
  input  tasc_pkg::item_t  item_i,
  output tasc_pkg::state_t state_o,
  output tasc_pkg::mid_t   mid_o
);
  import tasc_pkg::*;

  logic [32:0] remote_age;
  logic        remote_live;
  logic        low_ok;
  alarm_e      cls;
  logic        snoozed;
  logic [32:0] sound_age;
  logic [15:0] repeat_sec;
  logic        repeat_due;
  logic        urgent;
  logic [31:0] press_gap;
  logic        in_window;
  logic [2:0]  mult_next;
  logic [15:0] snooze_sec;
  logic [32:0] until_sum;
  logic [31:0] until_sat;
  state_t      st;
  logic        changed;
  sound_e      sound;

  assign remote_age  = {1'b0, item_i.now_sec} - {1'b0, state_i.remote_since};
  assign remote_live = (state_i.remote_held != 3'd0) &&
                       (remote_age[32] || (remote_age[31:0] < RemoteHoldSec));
  assign low_ok      = item_i.glucose_mgdl >= MinValidMgdl;

  always_comb begin
    if (!cfg_i.alarms_enabled) begin
      cls = ALARM_IDLE;
    end else if (remote_live) begin
      cls = ALARM_EXTERNAL;
    end else if (!item_i.has_data) begin
      cls = ALARM_IDLE;
    end else if (!item_i.reading_stale && low_ok &&
                 item_i.glucose_mgdl <= cfg_i.alarm_low) begin
      cls = ALARM_LOW;
    end else if (!item_i.reading_stale && low_ok &&
                 item_i.glucose_mgdl <= cfg_i.warn_low) begin
      cls = ALARM_CAUTION_LOW;
    end else if (!item_i.reading_stale && item_i.glucose_mgdl >= cfg_i.alarm_high) begin
      cls = ALARM_HIGH;
    end else if (!item_i.reading_stale && item_i.glucose_mgdl >= cfg_i.warn_high) begin
      cls = ALARM_CAUTION_HIGH;
    end else if (item_i.minutes_since_reading >= {8'd0, cfg_i.no_readings_min}) begin
      cls = ALARM_NO_READ;
    end else begin
      cls = ALARM_IDLE;
    end
  end

  assign snoozed    = (state_i.snooze_until != 32'd0) &&
                      (item_i.now_sec < state_i.snooze_until);
  assign sound_age  = {1'b0, item_i.now_sec} - {1'b0, state_i.last_sound_time};
  assign repeat_sec = 16'(cfg_i.repeat_min) * SecPerMin;
  assign repeat_due = !state_i.ever_sounded ||
                      (!sound_age[32] && (sound_age[31:0] > {16'd0, repeat_sec}));
  assign urgent     = (cls inside {ALARM_LOW, ALARM_HIGH}) ||
                      ((cls == ALARM_EXTERNAL) &&
                       (state_i.remote_held inside {RemoteUrgentLow, RemoteUrgentHigh}));

  assign press_gap  = item_i.now_ms - state_i.last_press_ms;
  assign in_window  = state_i.press_valid && (press_gap < PressWindowMs);
  assign mult_next  = !in_window ? 3'd1 :
                      (state_i.snooze_mult == MaxSnoozeMult) ? 3'd0 :
                      state_i.snooze_mult + 3'd1;
  assign snooze_sec = 16'(mult_next) * 16'(cfg_i.snooze_min) * SecPerMin;
  assign until_sum  = {1'b0, item_i.now_sec} + {17'd0, snooze_sec};
  assign until_sat  = until_sum[32] ? '1 : until_sum[31:0];

  always_comb begin
    st      = state_i;
    changed = 1'b0;
    sound   = SOUND_NONE;
    case (item_i.operation)
      OP_EVAL: begin
        if (cls != state_i.cur_alarm) begin
          st.cur_alarm = cls;
          changed      = 1'b1;
          if (cls == ALARM_IDLE) begin
            st.ever_sounded = 1'b0;
          end
        end
        if (cls != ALARM_IDLE && !snoozed && repeat_due) begin
          st.last_sound_time = item_i.now_sec;
          st.ever_sounded    = 1'b1;
          sound              = urgent ? SOUND_URGENT : SOUND_WARN;
        end
      end
      OP_PRESS: begin
        if (state_i.cur_alarm != ALARM_IDLE || snoozed) begin
          st.snooze_mult   = mult_next;
          st.last_press_ms = item_i.now_ms;
          st.press_valid   = 1'b1;
          st.snooze_until  = (mult_next == 3'd0) ? 32'd0 : until_sat;
          changed          = 1'b1;
        end
      end
      OP_REMOTE: begin
        if (item_i.remote_code == 3'd0) begin
          st.remote_held = 3'd0;
        end else begin
          st.remote_held  = item_i.remote_code;
          st.remote_since = item_i.now_sec;
          st.ever_sounded = 1'b0;
        end
      end
      OP_CLEAR: begin
        st.snooze_until = 32'd0;
        st.snooze_mult  = 3'd0;
        changed         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign state_o = st;

  always_comb begin
    mid_o.alarm            = st.cur_alarm;
    mid_o.changed          = changed;
    mid_o.sound            = sound;
    mid_o.snooze_mult      = st.snooze_mult;
    mid_o.snooze_until     = st.snooze_until;
    mid_o.remote_held      = st.remote_held;
    mid_o.last_sound_time  = st.last_sound_time;
    mid_o.now_sec          = item_i.now_sec;
    mid_o.has_data         = item_i.has_data;
    mid_o.reading_time_sec = item_i.reading_time_sec;
  end

endmodule

// File: hw/rtl/tasc_finish.sv
module tasc_finish (
  input  tasc_pkg::cfg_t cfg_i,
  input  tasc_pkg::mid_t mid_i,
  output logic [9:0]     snooze_left_min_o,
  output logic [31:0]    next_wake_sec_o
);
  import tasc_pkg::*;

  logic        snz_run;
  logic [32:0] ceil_num;
  logic [30:0] quarter;
  logic [62:0] quot_prod;
  logic [15:0] repeat_sec;
  logic [15:0] noread_sec;
  logic        has_alarm;
  logic [31:0] add_base;
  logic [15:0] add_off;
  logic [32:0] wake_sum;
  logic [31:0] wake_sat;
  logic [31:0] cand;
  logic [31:0] cand_max;

  assign snz_run   = (mid_i.snooze_until != 32'd0) && (mid_i.snooze_until > mid_i.now_sec);
  assign ceil_num  = {1'b0, mid_i.snooze_until} + CeilMinBias - {1'b0, mid_i.now_sec};
  assign quarter   = ceil_num[32:2];
  assign quot_prod = 63'(quarter) * 63'(Div15Magic);
  assign snooze_left_min_o = snz_run ? 10'(quot_prod >> Div15Shift) : 10'd0;

  assign repeat_sec = 16'(cfg_i.repeat_min) * SecPerMin;
  assign noread_sec = 16'(cfg_i.no_readings_min) * SecPerMin;
  assign has_alarm  = mid_i.alarm != ALARM_IDLE;
  assign add_base   = has_alarm ? mid_i.last_sound_time : mid_i.reading_time_sec;
  assign add_off    = has_alarm ? repeat_sec : noread_sec;
  assign wake_sum   = {1'b0, add_base} + {17'd0, add_off};
  assign wake_sat   = wake_sum[32] ? '1 : wake_sum[31:0];
  assign cand       = (has_alarm && snz_run) ? mid_i.snooze_until : wake_sat;
  assign cand_max   = (cand <= mid_i.now_sec) ? mid_i.now_sec : cand;

  always_comb begin
    if (!cfg_i.alarms_enabled) begin
      next_wake_sec_o = 32'd0;
    end else if (has_alarm) begin
      next_wake_sec_o = cand_max;
    end else if (mid_i.has_data && mid_i.reading_time_sec != 32'd0) begin
      next_wake_sec_o = cand_max;
    end else begin
      next_wake_sec_o = 32'd0;
    end
  end

endmodule

// File: verif/threshold_alarm_snooze_controller_test.sv
`timescale 1ns / 100ps

module threshold_alarm_snooze_controller_test;
  import tasc_pkg::*;

  typedef struct packed {
    alarm_e      alarm;
    logic        changed;
    sound_e      sound;
    logic [2:0]  level;
    logic [9:0]  left_min;
    logic [2:0]  remote;
    logic [31:0] wake_sec;
  } outcome_t;

  typedef struct {
    item_t    ev;
    bit       typed;
    outcome_t want;
  } script_row_t;

  typedef enum {READY_ALWAYS, READY_MOSTLY, READY_SELDOM, READY_PERIODIC} ready_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [9:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  op_e         operation_i;
  logic [31:0] now_sec_i;
  logic [31:0] now_ms_i;
  logic        has_data_i;
  logic [9:0]  glucose_mgdl_i;
  logic        reading_stale_i;
  logic [15:0] minutes_since_reading_i;
  logic [31:0] reading_time_sec_i;
  logic [2:0]  remote_code_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  alarm_state_o;
  logic        state_changed_o;
  logic [1:0]  sound_request_o;
  logic [2:0]  snooze_level_o;
  logic [9:0]  snooze_left_min_o;
  logic [2:0]  active_remote_code_o;
  logic [31:0] next_wake_sec_o;

  threshold_alarm_snooze_controller u_dut (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_idx_i               (cfg_idx_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .in_valid_i              (in_valid_i),
    .in_ready_o              (in_ready_o),
    .operation_i             (operation_i),
    .now_sec_i               (now_sec_i),
    .now_ms_i                (now_ms_i),
    .has_data_i              (has_data_i),
    .glucose_mgdl_i          (glucose_mgdl_i),
    .reading_stale_i         (reading_stale_i),
    .minutes_since_reading_i (minutes_since_reading_i),
    .reading_time_sec_i      (reading_time_sec_i),
    .remote_code_i           (remote_code_i),
    .out_valid_o             (out_valid_o),
    .out_ready_i             (out_ready_i),
    .alarm_state_o           (alarm_state_o),
    .state_changed_o         (state_changed_o),
    .sound_request_o         (sound_request_o),
    .snooze_level_o          (snooze_level_o),
    .snooze_left_min_o       (snooze_left_min_o),
    .active_remote_code_o    (active_remote_code_o),
    .next_wake_sec_o         (next_wake_sec_o)
  );

  cfg_t        setting;
  alarm_e      cur_alarm;
  bit          sounded;
  bit [31:0]   sound_at;
  bit [2:0]    remote_held;
  bit [31:0]   remote_at;
  bit [2:0]    snooze_lvl;
  bit [31:0]   snooze_end;
  bit [31:0]   press_at_ms;
  bit          press_seen;

  outcome_t    pending_results[$];
  script_row_t script[$];
  outcome_t    front;
  bit [31:0]   wall_sec;
  bit [31:0]   tick_ms;
  int unsigned burst_left;
  int unsigned events_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned settings_loaded;
  int unsigned sounds_predicted;
  int unsigned presses_taken;
  int unsigned ready_tick;
  ready_mode_e ready_mode;
  cfg_t        plan;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic longint span(bit [31:0] a, bit [31:0] b);
    return longint'({32'b0, a}) - longint'({32'b0, b});
  endfunction

  function automatic bit [31:0] add_sat(bit [31:0] a, bit [63:0] b);
    bit [63:0] s;
    s = 64'(a) + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit snooze_running(bit [31:0] now);
    return snooze_end != 32'd0 && now < snooze_end;
  endfunction

  function automatic alarm_e classify_reading(item_t ev);
    if (!setting.alarms_enabled) return ALARM_IDLE;
    if (remote_held != 3'd0 && span(ev.now_sec, remote_at) < longint'(RemoteHoldSec))
      return ALARM_EXTERNAL;
    if (!ev.has_data) return ALARM_IDLE;
    if (!ev.reading_stale) begin
      if (ev.glucose_mgdl >= MinValidMgdl && ev.glucose_mgdl <= setting.alarm_low)
        return ALARM_LOW;
      if (ev.glucose_mgdl >= MinValidMgdl && ev.glucose_mgdl <= setting.warn_low)
        return ALARM_CAUTION_LOW;
      if (ev.glucose_mgdl >= setting.alarm_high) return ALARM_HIGH;
      if (ev.glucose_mgdl >= setting.warn_high) return ALARM_CAUTION_HIGH;
    end
    if (ev.minutes_since_reading >= setting.no_readings_min) return ALARM_NO_READ;
    return ALARM_IDLE;
  endfunction

  function automatic outcome_t step_alarm(item_t ev);
    outcome_t  r;
    alarm_e    seen;
    bit        due;
    bit        urgent;
    bit        has_target;
    longint    d;
    bit [31:0] now;
    bit [31:0] target;
    r = '0;
    now = ev.now_sec;
    has_target = 1'b0;
    target = '0;
    case (ev.operation)
      OP_EVAL: begin
        seen = classify_reading(ev);
        if (seen != cur_alarm) begin
          cur_alarm = seen;
          r.changed = 1'b1;
          if (seen == ALARM_IDLE) sounded = 1'b0;
        end
        if (seen != ALARM_IDLE && !snooze_running(now)) begin
          due = !sounded || span(now, sound_at) > longint'(setting.repeat_min) * 60;
          if (due) begin
            urgent = seen == ALARM_LOW || seen == ALARM_HIGH ||
                     (seen == ALARM_EXTERNAL &&
                      (remote_held == RemoteUrgentLow || remote_held == RemoteUrgentHigh));
            sound_at = now;
            sounded = 1'b1;
            r.sound = urgent ? SOUND_URGENT : SOUND_WARN;
            sounds_predicted++;
          end
        end
      end
      OP_PRESS: begin
        if (cur_alarm != ALARM_IDLE || snooze_running(now)) begin
          if (press_seen && ev.now_ms - press_at_ms < PressWindowMs)
            snooze_lvl = (snooze_lvl >= MaxSnoozeMult) ? 3'd0 : snooze_lvl + 3'd1;
          else
            snooze_lvl = 3'd1;
          press_at_ms = ev.now_ms;
          press_seen = 1'b1;
          if (snooze_lvl == 3'd0)
            snooze_end = '0;
          else
            snooze_end = add_sat(now, 64'(snooze_lvl) * 64'(setting.snooze_min) * 64'd60);
          r.changed = 1'b1;
          presses_taken++;
        end
      end
      OP_REMOTE: begin
        if (ev.remote_code == 3'd0) begin
          remote_held = '0;
        end else begin
          remote_held = ev.remote_code;
          remote_at = now;
          sounded = 1'b0;
        end
      end
      OP_CLEAR: begin
        snooze_end = '0;
        snooze_lvl = '0;
        r.changed = 1'b1;
      end
      default: ;
    endcase
    if (snooze_end != 32'd0) begin
      d = span(snooze_end, now);
      if (d > 0) r.left_min = 10'((d + 59) / 60);
    end
    if (setting.alarms_enabled) begin
      if (cur_alarm != ALARM_IDLE) begin
        has_target = 1'b1;
        target = snooze_running(now) ? snooze_end :
                 add_sat(sound_at, 64'(setting.repeat_min) * 64'd60);
      end else if (ev.has_data && ev.reading_time_sec != 32'd0) begin
        has_target = 1'b1;
        target = add_sat(ev.reading_time_sec, 64'(setting.no_readings_min) * 64'd60);
      end
      if (has_target) r.wake_sec = (target <= now) ? now : target;
    end
    r.alarm = cur_alarm;
    r.level = snooze_lvl;
    r.remote = remote_held;
    return r;
  endfunction

  function automatic item_t mk_event(op_e op, bit [31:0] sec, bit [31:0] ms, bit hd,
                                     bit [9:0] g, bit st, bit [15:0] mins,
                                     bit [31:0] rt, bit [2:0] code);
    item_t ev;
    ev.operation = op;
    ev.now_sec = sec;
    ev.now_ms = ms;
    ev.has_data = hd;
    ev.glucose_mgdl = g;
    ev.reading_stale = st;
    ev.minutes_since_reading = mins;
    ev.reading_time_sec = rt;
    ev.remote_code = code;
    return ev;
  endfunction

  function automatic item_t next_event();
    item_t ev;
    int    pick;
    int    advance;
    ev = '0;
    pick = $urandom_range(0, 99);
    if (pick < 55)      ev.operation = OP_EVAL;
    else if (pick < 77) ev.operation = OP_PRESS;
    else if (pick < 90) ev.operation = OP_REMOTE;
    else                ev.operation = OP_CLEAR;
    if (ev.operation == OP_PRESS && $urandom_range(0, 3) != 0) begin
      wall_sec += 32'($urandom_range(0, 2));
      tick_ms += 32'($urandom_range(0, 2300));
    end else begin
      advance = $urandom_range(0, 700);
      wall_sec += 32'(advance);
      tick_ms += 32'(advance * 1000 + $urandom_range(0, 999));
    end
    ev.now_sec = wall_sec;
    ev.now_ms = tick_ms;
    ev.has_data = $urandom_range(0, 9) != 0;
    case ($urandom_range(0, 5))
      0: ev.glucose_mgdl = setting.alarm_low + 10'($urandom_range(0, 6)) - 10'd3;
      1: ev.glucose_mgdl = setting.warn_low + 10'($urandom_range(0, 6)) - 10'd3;
      2: ev.glucose_mgdl = setting.alarm_high + 10'($urandom_range(0, 6)) - 10'd3;
      3: ev.glucose_mgdl = setting.warn_high + 10'($urandom_range(0, 6)) - 10'd3;
      4: ev.glucose_mgdl = MinValidMgdl + 10'($urandom_range(0, 4)) - 10'd2;
      default: ev.glucose_mgdl = 10'($urandom_range(0, 1023));
    endcase
    ev.reading_stale = $urandom_range(0, 4) == 0;
    case ($urandom_range(0, 2))
      0: ev.minutes_since_reading = 16'(setting.no_readings_min) +
                                    16'($urandom_range(0, 4)) - 16'd2;
      1: ev.minutes_since_reading = 16'($urandom_range(0, 30));
      default: ev.minutes_since_reading = 16'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0: ev.reading_time_sec = '0;
      1: ev.reading_time_sec = $urandom();
      default: ev.reading_time_sec = wall_sec - 32'(ev.minutes_since_reading) * 32'd60;
    endcase
    ev.remote_code = 3'($urandom_range(0, 7));
    if (ev.operation == OP_REMOTE && $urandom_range(0, 2) == 0) ev.remote_code = '0;
    if ($urandom_range(0, 9) == 0) begin
      ev.operation = op_e'($urandom_range(0, 3));
      ev.now_sec = $urandom();
      ev.now_ms = $urandom();
      ev.glucose_mgdl = 10'($urandom());
      ev.minutes_since_reading = 16'($urandom());
    end
    return ev;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic put_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgAlarmsEnabled: setting.alarms_enabled = val[0];
      CfgAlarmLow:      setting.alarm_low = val;
      CfgWarnLow:       setting.warn_low = val;
      CfgAlarmHigh:     setting.alarm_high = val;
      CfgWarnHigh:      setting.warn_high = val;
      CfgNoReadingsMin: setting.no_readings_min = val[7:0];
      CfgRepeatMin:     setting.repeat_min = val[7:0];
      CfgSnoozeMin:     setting.snooze_min = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(cfg_t c);
    put_reg(CfgAlarmsEnabled, 10'(c.alarms_enabled));
    put_reg(CfgAlarmLow, c.alarm_low);
    put_reg(CfgWarnLow, c.warn_low);
    put_reg(CfgAlarmHigh, c.alarm_high);
    put_reg(CfgWarnHigh, c.warn_high);
    put_reg(CfgNoReadingsMin, 10'(c.no_readings_min));
    put_reg(CfgRepeatMin, 10'(c.repeat_min));
    put_reg(CfgSnoozeMin, 10'(c.snooze_min));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic send_event(item_t ev, bit typed, outcome_t want);
    outcome_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    operation_i <= ev.operation;
    now_sec_i <= ev.now_sec;
    now_ms_i <= ev.now_ms;
    has_data_i <= ev.has_data;
    glucose_mgdl_i <= ev.glucose_mgdl;
    reading_stale_i <= ev.reading_stale;
    minutes_since_reading_i <= ev.minutes_since_reading;
    reading_time_sec_i <= ev.reading_time_sec;
    remote_code_i <= ev.remote_code;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_alarm(ev);
    pending_results.push_back(typed ? want : predicted);
    events_sent++;
    burst_left--;
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    ready_tick++;
    if (ready_tick % 64 == 0) ready_mode <= ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_MOSTLY:   out_ready_i <= $urandom_range(0, 3) != 0;
      READY_SELDOM:   out_ready_i <= $urandom_range(0, 3) == 0;
      default:        out_ready_i <= ready_tick % 5 != 0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat arrived with nothing pending");
        mismatches++;
      end else begin
        front = pending_results.pop_front();
        check_field("alarm_state", 32'(front.alarm), 32'(alarm_state_o));
        check_field("state_changed", 32'(front.changed), 32'(state_changed_o));
        check_field("sound_request", 32'(front.sound), 32'(sound_request_o));
        check_field("snooze_level", 32'(front.level), 32'(snooze_level_o));
        check_field("snooze_left_min", 32'(front.left_min), 32'(snooze_left_min_o));
        check_field("active_remote_code", 32'(front.remote), 32'(active_remote_code_o));
        check_field("next_wake_sec", front.wake_sec, next_wake_sec_o);
        results_checked++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgAlarmsEnabled;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    operation_i = OP_EVAL;
    now_sec_i = '0;
    now_ms_i = '0;
    has_data_i = 1'b0;
    glucose_mgdl_i = '0;
    reading_stale_i = 1'b0;
    minutes_since_reading_i = '0;
    reading_time_sec_i = '0;
    remote_code_i = '0;
    ready_mode = READY_ALWAYS;

    setting = '{alarms_enabled: 1'b1, alarm_low: 10'd55, warn_low: 10'd70,
                alarm_high: 10'd260, warn_high: 10'd180, no_readings_min: 8'd15,
                repeat_min: 8'd5, snooze_min: 8'd30};
    cur_alarm = ALARM_IDLE;
    sounded = 1'b0;
    sound_at = '0;
    remote_held = '0;
    remote_at = '0;
    snooze_lvl = '0;
    snooze_end = '0;
    press_at_ms = '0;
    press_seen = 1'b0;

    script.push_back('{mk_event(OP_EVAL, 100, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                       '{ALARM_IDLE, 1'b0, SOUND_NONE, 3'd0, 10'd0, 3'd0, 32'd0}});
    script.push_back('{mk_event(OP_EVAL, 1000, 0, 1, 10, 0, 0, 990, 0), 1'b1,
                       '{ALARM_LOW, 1'b1, SOUND_URGENT, 3'd0, 10'd0, 3'd0, 32'd1300}});
    script.push_back('{mk_event(OP_PRESS, 1000, 0, 1, 10, 0, 0, 990, 0), 1'b1,
                       '{ALARM_LOW, 1'b1, SOUND_NONE, 3'd1, 10'd30, 3'd0, 32'd2800}});
    script.push_back('{mk_event(OP_PRESS, 1001, 1999, 1, 10, 0, 0, 990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_PRESS, 1002, 3998, 1, 10, 0, 0, 990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_PRESS, 1003, 5997, 1, 10, 0, 0, 990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_PRESS, 1004, 7996, 1, 10, 0, 0, 990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_PRESS, 1005, 9996, 1, 10, 0, 0, 990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_CLEAR, 1010, 0, 1, 10, 0, 0, 990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 1100, 0, 1, 9, 0, 0, 1100, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_PRESS, 1100, 20000, 1, 9, 0, 0, 1100, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 1200, 0, 1, 70, 0, 0, 1190, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 1300, 0, 1, 1023, 0, 0, 1290, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 1600, 0, 1, 180, 0, 0, 1590, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 1700, 0, 1, 1023, 1, 16'hFFFF, 1, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 1800, 0, 1, 100, 0, 14, 0, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_REMOTE, 2000, 0, 1, 100, 0, 0, 1990, RemoteUrgentHigh),
                       1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 2000, 0, 1, 100, 0, 0, 1990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 3799, 0, 1, 100, 0, 0, 3790, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 3800, 0, 1, 55, 0, 0, 3790, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_REMOTE, 5000, 0, 1, 100, 0, 0, 3790, 3'd2), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 4000, 0, 1, 100, 0, 0, 3990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_REMOTE, 4000, 0, 1, 100, 0, 0, 3990, 0), 1'b0, '0});
    script.push_back('{mk_event(OP_EVAL, 32'hFFFF_FF00, 0, 1, 1023, 0, 0, 32'hFFFF_FF00, 0),
                       1'b0, '0});
    script.push_back('{mk_event(OP_PRESS, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1, 1023, 0, 0,
                                32'hFFFF_FF00, 0), 1'b0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_event(script[i].ev, script[i].typed, script[i].want);
    in_valid_i <= 1'b0;

    for (int round = 0; round < 6; round++) begin
      settle();
      plan = '0;
      case (round)
        0, 4: begin
          plan.alarms_enabled = 1'b1;
          plan.alarm_low = 10'($urandom_range(20, 80));
          plan.warn_low = plan.alarm_low + 10'($urandom_range(0, 40));
          plan.warn_high = 10'($urandom_range(140, 220));
          plan.alarm_high = plan.warn_high + 10'($urandom_range(0, 100));
          plan.no_readings_min = 8'($urandom_range(1, 30));
          plan.repeat_min = 8'($urandom_range(0, 10));
          plan.snooze_min = 8'($urandom_range(0, 60));
        end
        1: plan = '0;
        2: plan = '1;
        3: plan.alarms_enabled = 1'b1;
        default: plan = cfg_t'({$urandom(), $urandom()});
      endcase
      load_settings(plan);
      case (round % 3)
        0: wall_sec = 32'($urandom_range(0, 5000));
        1: wall_sec = $urandom();
        default: wall_sec = 32'hFFFF_0000 + 32'($urandom_range(0, 4000));
      endcase
      tick_ms = $urandom();
      repeat (160) send_event(next_event(), 1'b0, '0);
      in_valid_i <= 1'b0;
    end
    settle();

    $display("%0d events over %0d register settings, %0d result beats compared",
             events_sent, settings_loaded + 1, results_checked);
    $display("%0d sound requests and %0d snooze presses taken, %0d mismatches",
             sounds_predicted, presses_taken, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
